### sv/rfbs_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the rarest-first block scheduler
package rfbs_pkg;

    localparam int MAX_PIECES  = 1024;
    localparam int PIECE_AW    = $clog2(MAX_PIECES);
    localparam int CNT_W       = PIECE_AW + 1;
    localparam int MAX_BLOCKS  = 64;
    localparam int SLOT_W      = $clog2(MAX_BLOCKS);
    localparam int NSLOT_W     = SLOT_W + 1;
    localparam int BLOCK_BYTES = 16384;
    localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int MAX_LEN     = MAX_BLOCKS * BLOCK_BYTES;
    localparam int LEN_W       = 21;
    localparam int OFF_W       = 20;
    localparam int BLEN_W      = 15;
    localparam int MAX_PEERS   = 16;
    localparam int PEER_W      = $clog2(MAX_PEERS);
    localparam int PEER_BYTES  = MAX_PIECES / 8;
    localparam int PBYTE_AW    = $clog2(PEER_BYTES);
    localparam int PEER_AW     = PEER_W + PBYTE_AW;
    localparam int REQ_BYTES   = 128;
    localparam int REQ_AW      = $clog2(REQ_BYTES);
    localparam int HOLD_W      = 5;
    localparam int HOLD_MAX    = 31;
    localparam int RECV_W      = 7;
    localparam int RECV_MAX    = 2 * MAX_BLOCKS - 1;
    localparam int FIN_MAX     = 2047;
    localparam int CLR_W       = PEER_AW;

    localparam logic [1:0] CFG_PIECE_COUNT = 2'd0;
    localparam logic [1:0] CFG_PIECE_LEN   = 2'd1;
    localparam logic [1:0] CFG_LAST_LEN    = 2'd2;

    typedef enum logic [2:0] {
        CMD_REQ     = 3'd0,
        CMD_DELIVER = 3'd1,
        CMD_RETURN  = 3'd2,
        CMD_PEER    = 3'd3,
        CMD_DROP    = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SCAN, S_COMMIT, S_OP_RD, S_OP_EX,
        S_PB_RD, S_PB_OLD, S_PH, S_DONE
    } t_state;

    typedef struct packed {
        logic                  fin;
        logic [HOLD_W-1:0]     hold;
        logic [NSLOT_W-1:0]    nslot;
        logic [MAX_BLOCKS-1:0] mask;
        logic                  inprog;
        logic [RECV_W-1:0]     recv;
    } t_piece;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [NSLOT_W-1:0] nblk;
    } t_geom;

endpackage

### sv/rfbs_ram.sv
`timescale 1ns / 1ps
// simple dual-port ram with registered read
module rfbs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rfbs_geom.sv
`timescale 1ns / 1ps
// piece length, block count and used piece count from the configuration
module rfbs_geom (
    input  logic [rfbs_pkg::CNT_W-1:0]    i_piece_count,
    input  logic [rfbs_pkg::LEN_W-1:0]    i_piece_length,
    input  logic [rfbs_pkg::LEN_W-1:0]    i_last_len,
    input  logic [rfbs_pkg::PIECE_AW-1:0] i_piece,
    output logic [rfbs_pkg::CNT_W-1:0]    o_count,
    output rfbs_pkg::t_geom               o_geom
);
    import rfbs_pkg::*;

    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_rnd;

    always_comb begin
        cnt = (i_piece_count > CNT_W'(MAX_PIECES)) ? CNT_W'(MAX_PIECES) : i_piece_count;
        if (i_piece_length == '0) begin
            len = LEN_W'(1);
        end else if (i_piece_length > LEN_W'(MAX_LEN)) begin
            len = LEN_W'(MAX_LEN);
        end else begin
            len = i_piece_length;
        end
        // last piece may be short
        if ((({1'b0, i_piece} + CNT_W'(1)) == cnt) && (i_last_len != '0) &&
            (i_last_len < len)) begin
            len = i_last_len;
        end
        len_rnd     = len + LEN_W'(BLOCK_BYTES - 1);
        o_geom.len  = len;
        o_geom.nblk = NSLOT_W'(len_rnd >> BLK_SHIFT);
        o_count     = cnt;
    end

endmodule

### sv/rarest_first_block_scheduler.sv
`timescale 1ns / 1ps
// top level: control sequencer around the piece, peer and request memories
//
// rarest-first block scheduler. all per-piece state (finished, holder count,
// next slot, outstanding mask, in-progress, received count) lives in one
// 1024-entry ram, the peer bitmaps in a 2048-byte ram and the request bitmap
// in a 128-byte ram. after reset a clearing pass zeroes the piece and peer
// rams; stall stays high meanwhile, config writes still land. one item is
// worked at a time. a request byte that is not the last is stored in the
// request ram; the last one scans every used piece through the piece ram
// read port, one per cycle. deliver and return are a read-modify-write of
// one entry. a peer byte works each bitmap byte touched by reading the old
// byte, writing the new one, then 8 holder-count updates; a peer byte with
// last set at byte b sweeps from b to the end of the bitmap and a drop of a
// valid peer sweeps all of it. the result goes to an output register, so
// the next item is taken while a result waits for its transfer.
module rarest_first_block_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    // input item
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [9:0]  i_piece_index,
    input  logic [19:0] i_offset,
    input  logic [14:0] i_length,
    input  logic        i_hash_ok,
    input  logic [3:0]  i_peer_slot,
    input  logic [6:0]  i_byte_index,
    input  logic [7:0]  i_bitmap_byte,
    input  logic        i_last_byte,
    // result item
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [9:0]  o_block_piece,
    output logic [19:0] o_block_offset,
    output logic [14:0] o_block_length,
    output logic        o_piece_done,
    output logic        o_download_complete,
    output logic [10:0] o_finished_total
);
    import rfbs_pkg::*;

    // free-slot search: lowest clear mask bit at or above start, below n
    function automatic logic [SLOT_W:0] find_free(
        input logic [MAX_BLOCKS-1:0] mask,
        input logic [NSLOT_W-1:0]    start,
        input logic [NSLOT_W-1:0]    n
    );
        logic              found;
        logic [SLOT_W-1:0] slot;
        found = 1'b0;
        slot  = '0;
        for (int s = MAX_BLOCKS - 1; s >= 0; s--) begin
            if (!mask[s] && (NSLOT_W'(s) >= start) && (NSLOT_W'(s) < n)) begin
                found = 1'b1;
                slot  = SLOT_W'(s);
            end
        end
        return {found, slot};
    endfunction

    // state and configuration
    t_state r_state, n_state;
    logic [CLR_W-1:0]  r_clr;
    logic [CNT_W-1:0]  r_pc;
    logic [LEN_W-1:0]  r_plen;
    logic [LEN_W-1:0]  r_llen;
    logic [MAX_PEERS-1:0] r_pvalid;
    logic [CNT_W-1:0]  r_fin;

    // latched item
    logic [2:0]          r_cmd;
    logic [PIECE_AW-1:0] r_piece;
    logic [OFF_W-1:0]    r_off;
    logic [BLEN_W-1:0]   r_len;
    logic                r_hok;
    logic [PEER_W-1:0]   r_slot;
    logic [REQ_AW-1:0]   r_bi;
    logic [7:0]          r_byte;
    logic                r_last;

    // scan
    logic [CNT_W-1:0]    r_q;
    logic                r_qv;
    logic [PIECE_AW-1:0] r_qe;
    logic                r_have;
    logic [PIECE_AW-1:0] r_best;
    logic [SLOT_W-1:0]   r_bslot;
    t_piece              r_bent;

    // peer sweep
    logic [PBYTE_AW-1:0] r_pb;
    logic [PBYTE_AW-1:0] r_pend;
    logic [7:0]          r_old;
    logic [7:0]          r_new;
    logic [3:0]          r_i;

    // staged and output result
    logic                r_res_ok;
    logic [PIECE_AW-1:0] r_res_bp;
    logic [OFF_W-1:0]    r_res_bo;
    logic [BLEN_W-1:0]   r_res_bl;
    logic                r_res_done;
    logic                r_ov;
    logic                r_o_ok;
    logic [PIECE_AW-1:0] r_o_bp;
    logic [OFF_W-1:0]    r_o_bo;
    logic [BLEN_W-1:0]   r_o_bl;
    logic                r_o_done;
    logic                r_o_dc;
    logic [CNT_W-1:0]    r_o_ft;

    // memory ports
    logic                pm_we;
    logic [PIECE_AW-1:0] pm_waddr, pm_raddr;
    t_piece              pm_wdata;
    logic [$bits(t_piece)-1:0] pm_rdata_raw;
    t_piece              pe;
    logic                pr_we;
    logic [PEER_AW-1:0]  pr_waddr, pr_raddr;
    logic [7:0]          pr_wdata, pr_rdata;
    logic                rq_we;
    logic [REQ_AW-1:0]   rq_raddr;
    logic [7:0]          rq_rdata;

    // geometry
    logic [PIECE_AW-1:0] g_piece;
    logic [CNT_W-1:0]    cnt;
    t_geom               g;

    logic in_acc;
    logic out_load;

    // datapath results
    t_piece              op_ent;
    logic                op_we, op_ok, op_done, op_finc;
    logic                ev_take;
    logic [SLOT_W:0]     ev_ff;
    t_piece              cm_ent;
    logic [OFF_W-1:0]    cm_bo;
    logic [BLEN_W-1:0]   cm_bl;
    t_piece              ph_ent;
    logic [2:0]          ph_idx;
    logic [7:0]          pb_nv;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_ov || !i_stall);
    assign pe       = t_piece'(pm_rdata_raw);

    rfbs_ram #(.DEPTH(MAX_PIECES), .WIDTH($bits(t_piece))) u_piece_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata_raw)
    );

    rfbs_ram #(.DEPTH(MAX_PEERS * PEER_BYTES), .WIDTH(8)) u_peer_ram (
        .i_clk   (i_clk),
        .i_we    (pr_we),
        .i_waddr (pr_waddr),
        .i_wdata (pr_wdata),
        .i_raddr (pr_raddr),
        .o_rdata (pr_rdata)
    );

    rfbs_ram #(.DEPTH(REQ_BYTES), .WIDTH(8)) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (rq_we),
        .i_waddr (i_byte_index),
        .i_wdata (i_bitmap_byte),
        .i_raddr (rq_raddr),
        .o_rdata (rq_rdata)
    );

    // geometry follows the piece under evaluation
    always_comb begin
        unique case (r_state)
            S_SCAN:   g_piece = r_qe;
            S_COMMIT: g_piece = r_best;
            default:  g_piece = r_piece;
        endcase
    end

    rfbs_geom u_geom (
        .i_piece_count  (r_pc),
        .i_piece_length (r_plen),
        .i_last_len     (r_llen),
        .i_piece        (g_piece),
        .o_count        (cnt),
        .o_geom         (g)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_command)
                        CMD_REQ:     n_state = i_last_byte ? S_SCAN : S_DONE;
                        CMD_DELIVER: n_state = S_OP_RD;
                        CMD_RETURN:  n_state = S_OP_RD;
                        CMD_PEER:    n_state = S_PB_RD;
                        CMD_DROP:    n_state = r_pvalid[i_peer_slot] ? S_PB_RD : S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if ((r_q >= cnt) && !r_qv) n_state = S_COMMIT;
            end
            S_COMMIT: n_state = S_DONE;
            S_OP_RD: begin
                n_state = ({1'b0, r_piece} < cnt) ? S_OP_EX : S_DONE;
            end
            S_OP_EX:  n_state = S_DONE;
            S_PB_RD:  n_state = S_PB_OLD;
            S_PB_OLD: n_state = S_PH;
            S_PH: begin
                if (r_i == 4'd8) n_state = (r_pb == r_pend) ? S_DONE : S_PB_RD;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = r_piece;
        pm_wdata = '0;
        pm_raddr = r_piece;
        pr_we    = 1'b0;
        pr_waddr = {r_slot, r_pb};
        pr_wdata = '0;
        pr_raddr = {r_slot, r_pb};
        rq_we    = in_acc && (i_command == CMD_REQ);
        rq_raddr = r_q[PIECE_AW-1:3];
        unique case (r_state)
            S_CLR: begin
                pm_we    = 1'b1;
                pm_waddr = r_clr[PIECE_AW-1:0];
                pr_we    = 1'b1;
                pr_waddr = r_clr;
            end
            S_SCAN: begin
                pm_raddr = r_q[PIECE_AW-1:0];
            end
            S_COMMIT: begin
                pm_we    = r_have;
                pm_waddr = r_best;
                pm_wdata = cm_ent;
            end
            S_OP_EX: begin
                pm_we    = op_we;
                pm_wdata = op_ent;
            end
            S_PB_OLD: begin
                pr_we    = 1'b1;
                pr_wdata = pb_nv;
            end
            S_PH: begin
                pm_raddr = {r_pb, r_i[2:0]};
                pm_we    = (r_i != 4'd0);
                pm_waddr = {r_pb, ph_idx};
                pm_wdata = ph_ent;
            end
            default: begin
            end
        endcase
    end

    // datapath: scan evaluation, commit, deliver/return, holder update
    always_comb begin
        logic [SLOT_W-1:0] s;
        logic [LEN_W-1:0]  rem;
        logic [BLEN_W-1:0] l;
        logic [2:0]        bp;

        // scan candidate
        ev_ff   = find_free(pe.mask, pe.nslot, g.nblk);
        ev_take = r_qv && !pe.fin && (r_qe[PIECE_AW-1:3] <= r_bi) &&
                  rq_rdata[3'd7 - r_qe[2:0]] && ev_ff[SLOT_W] &&
                  (!r_have || (pe.hold < r_bent.hold) ||
                   ((pe.hold == r_bent.hold) && !pe.inprog && r_bent.inprog));

        // commit of the chosen block
        cm_ent             = r_bent;
        cm_ent.mask[r_bslot] = 1'b1;
        cm_ent.nslot       = NSLOT_W'(r_bslot) + NSLOT_W'(1);
        cm_bo              = {r_bslot, BLK_SHIFT'(0)};
        rem                = g.len - LEN_W'(cm_bo);
        cm_bl              = (rem < LEN_W'(BLOCK_BYTES)) ? BLEN_W'(rem) : BLEN_W'(BLOCK_BYTES);

        // deliver / return
        op_ent  = pe;
        op_we   = 1'b0;
        op_ok   = 1'b0;
        op_done = 1'b0;
        op_finc = 1'b0;
        s       = r_off[OFF_W-1:BLK_SHIFT];
        rem     = g.len - LEN_W'(r_off);
        l       = (rem < LEN_W'(BLOCK_BYTES)) ? BLEN_W'(rem) : BLEN_W'(BLOCK_BYTES);
        if (r_cmd == CMD_DELIVER) begin
            if (pe.fin) begin
                op_ok = 1'b1;
            end else begin
                op_we = 1'b1;
                if (!op_ent.inprog) begin
                    op_ent.inprog = 1'b1;
                    op_ent.recv   = '0;
                end
                if ((LEN_W'(r_off) + LEN_W'(r_len)) <= g.len) begin
                    if (op_ent.recv < RECV_W'(RECV_MAX)) op_ent.recv = op_ent.recv + 1'b1;
                    if ((r_off[BLK_SHIFT-1:0] == '0) && (NSLOT_W'(s) < g.nblk)) begin
                        op_ent.mask[s] = 1'b0;
                    end
                    op_ok = 1'b1;
                    if (op_ent.recv >= g.nblk) begin
                        op_ent.inprog = 1'b0;
                        if (r_hok) begin
                            op_ent.fin = 1'b1;
                            op_finc    = 1'b1;
                            op_done    = 1'b1;
                        end else begin
                            op_ent.nslot = '0;
                            op_ok        = 1'b0;
                        end
                    end
                end
            end
        end else begin
            // return: aligned, inside, clamped length, outstanding
            if ((r_off[BLK_SHIFT-1:0] == '0) && (NSLOT_W'(s) < g.nblk) &&
                (r_len == l) && pe.mask[s]) begin
                op_we = 1'b1;
                if (NSLOT_W'(s) < pe.nslot) op_ent.nslot = NSLOT_W'(s);
                op_ent.mask[s] = 1'b0;
                op_ok = 1'b1;
            end
        end

        // holder count update for one piece of the current peer byte
        ph_idx = r_i[2:0] - 3'd1;
        bp     = 3'd7 - ph_idx;
        ph_ent = pe;
        if (r_old[bp] && !r_new[bp] && (pe.hold != '0)) begin
            ph_ent.hold = pe.hold - 1'b1;
        end
        if (r_new[bp] && !r_old[bp] && (pe.hold < HOLD_W'(HOLD_MAX))) begin
            ph_ent.hold = pe.hold + 1'b1;
        end

        pb_nv = ((r_cmd == CMD_PEER) && (r_pb == r_bi)) ? r_byte : 8'd0;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_pc     <= CNT_W'(MAX_PIECES);
            r_plen   <= LEN_W'(262144);
            r_llen   <= '0;
            r_pvalid <= '0;
            r_fin    <= '0;
            r_qv     <= 1'b0;
            r_have   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIECE_COUNT: r_pc   <= i_cfg_data[CNT_W-1:0];
                    CFG_PIECE_LEN:   r_plen <= i_cfg_data;
                    CFG_LAST_LEN:    r_llen <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_have <= 1'b0;
                r_qv   <= 1'b0;
                if (i_command == CMD_PEER) r_pvalid[i_peer_slot] <= 1'b1;
                if (i_command == CMD_DROP) r_pvalid[i_peer_slot] <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_qv <= (r_q < cnt);
                if (ev_take) r_have <= 1'b1;
            end
            if ((r_state == S_OP_EX) && op_finc && (r_fin < CNT_W'(FIN_MAX))) begin
                r_fin <= r_fin + 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_command;
            r_piece    <= i_piece_index;
            r_off      <= i_offset;
            r_len      <= i_length;
            r_hok      <= i_hash_ok;
            r_slot     <= i_peer_slot;
            r_bi       <= i_byte_index;
            r_byte     <= i_bitmap_byte;
            r_last     <= i_last_byte;
            r_q        <= '0;
            r_res_ok   <= 1'b0;
            r_res_bp   <= '0;
            r_res_bo   <= '0;
            r_res_bl   <= '0;
            r_res_done <= 1'b0;
            // peer sweep range
            if (i_command == CMD_PEER) begin
                r_pb   <= i_byte_index;
                r_pend <= i_last_byte ? PBYTE_AW'(PEER_BYTES - 1) : i_byte_index;
            end else begin
                r_pb   <= '0;
                r_pend <= PBYTE_AW'(PEER_BYTES - 1);
            end
        end
        unique case (r_state)
            S_SCAN: begin
                if (r_q < cnt) r_q <= r_q + 1'b1;
                r_qe <= r_q[PIECE_AW-1:0];
                if (ev_take) begin
                    r_best  <= r_qe;
                    r_bslot <= ev_ff[SLOT_W-1:0];
                    r_bent  <= pe;
                end
            end
            S_COMMIT: begin
                if (r_have) begin
                    r_res_ok <= 1'b1;
                    r_res_bp <= r_best;
                    r_res_bo <= cm_bo;
                    r_res_bl <= cm_bl;
                end
            end
            S_OP_EX: begin
                r_res_ok   <= op_ok;
                r_res_done <= op_done;
            end
            S_PB_OLD: begin
                r_old <= pr_rdata;
                r_new <= pb_nv;
                r_i   <= '0;
            end
            S_PH: begin
                r_i <= r_i + 1'b1;
                if (r_i == 4'd8) r_pb <= r_pb + 1'b1;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_o_ok   <= r_res_ok;
            r_o_bp   <= r_res_bp;
            r_o_bo   <= r_res_bo;
            r_o_bl   <= r_res_bl;
            r_o_done <= r_res_done;
            r_o_dc   <= (r_fin >= cnt);
            r_o_ft   <= r_fin;
        end
    end

    assign o_valid             = r_ov;
    assign o_ok                = r_o_ok;
    assign o_block_piece       = r_o_bp;
    assign o_block_offset      = r_o_bo;
    assign o_block_length      = r_o_bl;
    assign o_piece_done        = r_o_done;
    assign o_download_complete = r_o_dc;
    assign o_finished_total    = r_o_ft;

`ifndef SYNTHESIS
    // the scan only reads piece state
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !pm_we)
        else $error("piece ram written during scan");

    // a chosen block lies inside its piece
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COMMIT) && r_have) |-> (NSLOT_W'(r_bslot) < g.nblk))
        else $error("committed slot beyond piece end");

    // a verified piece is always an accepted delivery
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_done) |-> r_o_ok)
        else $error("piece done without ok");
`endif

endmodule
